// ===== sv/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg: shared types, constants and helpers of the running median block
// Holds the field widths, the controller command codes, the state encoding
// and the heap ordering function.
// ----------------------------------------------------------------------------
package rmth_pkg;

  // Default number of samples the block can hold.
  localparam int unsigned CAPACITY_DEF = 1024;

  // Fixed field widths of the channels.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEDIAN_W = 33;
  localparam int unsigned COUNT_W  = 11;

  // Heap selector: the lower half is a max-heap, the upper half a min-heap.
  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DROP,
    OP_INSERT,
    OP_PUSH_RD,
    OP_PUSH_MOVE,
    OP_PUSH_WR,
    OP_POP_START,
    OP_POP_LAST,
    OP_POP_RD,
    OP_POP_RDL,
    OP_POP_MOVE,
    OP_POP_WR,
    OP_OUT
  } dp_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_PUSH_CHK,
    S_PUSH_CMP,
    S_PUSH_WR,
    S_REBAL,
    S_POP_LAST,
    S_POP_CHK,
    S_POP_RDL,
    S_POP_CMP,
    S_POP_WR,
    S_DONE
  } ctrl_state_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic idx_zero;
    logic push_up;
    logic rebal;
    logic l_in;
    logic pop_down;
    logic out_full;
  } dp_status_t;

  // True when a belongs above b in the selected heap.
  function automatic logic ranks_above(logic signed [SAMPLE_W-1:0] a,
                                       logic signed [SAMPLE_W-1:0] b,
                                       logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

// ===== sv/rmth_in_if.sv =====
// ----------------------------------------------------------------------------
// rmth_in_if: sample channel
// Valid/ready channel that carries one signed sample per request.
// ----------------------------------------------------------------------------
interface rmth_in_if
  import rmth_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/rmth_out_if.sv =====
// ----------------------------------------------------------------------------
// rmth_out_if: result channel
// Valid/ready channel that carries the doubled median, the drop flag and
// the number of held samples.
// ----------------------------------------------------------------------------
interface rmth_out_if
  import rmth_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic                       dropped;
  logic [COUNT_W-1:0]         stored_count;

  modport source (output valid, output median_doubled, output dropped,
                  output stored_count, input ready);
  modport sink (input valid, input median_doubled, input dropped,
                input stored_count, output ready);
endinterface

// ===== sv/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 514,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/rmth_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmth_ctrl: sequencer of the running median block
// Steps through insertion, sift-up, rebalancing pop with sift-down, and
// result hand-off, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module rmth_ctrl
  import rmth_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  ctrl_state_e state_q, state_d;
  logic        phase_q, phase_d;

  // State and phase registers; the phase marks the rebalancing push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        phase_d = 1'b0;
        state_d = status_i.full ? S_DONE : S_PUSH_CHK;
      end
      S_PUSH_CHK: begin
        state_d = status_i.idx_zero ? S_PUSH_WR : S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        state_d = status_i.push_up ? S_PUSH_CHK : S_PUSH_WR;
      end
      S_PUSH_WR: begin
        state_d = phase_q ? S_DONE : S_REBAL;
      end
      S_REBAL: begin
        state_d = status_i.rebal ? S_POP_LAST : S_DONE;
      end
      S_POP_LAST: state_d = S_POP_CHK;
      S_POP_CHK: begin
        state_d = status_i.l_in ? S_POP_RDL : S_POP_WR;
      end
      S_POP_RDL: state_d = S_POP_CMP;
      S_POP_CMP: begin
        state_d = status_i.pop_down ? S_POP_CHK : S_POP_WR;
      end
      S_POP_WR: begin
        phase_d = 1'b1;
        state_d = S_PUSH_CHK;
      end
      S_DONE: begin
        if (!status_i.out_full) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      S_DECIDE:   op_o = status_i.full ? OP_DROP : OP_INSERT;
      S_PUSH_CHK: op_o = status_i.idx_zero ? OP_NONE : OP_PUSH_RD;
      S_PUSH_CMP: op_o = status_i.push_up ? OP_PUSH_MOVE : OP_NONE;
      S_PUSH_WR:  op_o = OP_PUSH_WR;
      S_REBAL:    op_o = status_i.rebal ? OP_POP_START : OP_NONE;
      S_POP_LAST: op_o = OP_POP_LAST;
      S_POP_CHK:  op_o = status_i.l_in ? OP_POP_RD : OP_NONE;
      S_POP_RDL:  op_o = OP_POP_RDL;
      S_POP_CMP:  op_o = status_i.pop_down ? OP_POP_MOVE : OP_NONE;
      S_POP_WR:   op_o = OP_POP_WR;
      S_DONE:     op_o = status_i.out_full ? OP_NONE : OP_OUT;
      default:    op_o = OP_NONE;
    endcase
  end

endmodule

// ===== sv/rmth_dp.sv =====
// ----------------------------------------------------------------------------
// rmth_dp: datapath of the running median block
// Two heap RAMs, their counts and cached tops, the hole index and value of
// the current sift, and the output register.
// ----------------------------------------------------------------------------
module rmth_dp
  import rmth_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  dp_op_e                     op_i,
  output dp_status_t                 status_o,
  rmth_out_if.source                 out_if
);

  localparam int unsigned HeapDepth = CAPACITY / 2 + 2;
  localparam int unsigned AW        = $clog2(HeapDepth);
  localparam int unsigned IW        = AW + 1;
  localparam int unsigned CW        = $clog2(HeapDepth + 1);
  localparam int unsigned TW        = $clog2(CAPACITY + 1);

  logic signed [SAMPLE_W-1:0] sample_q, val_q, top_q, left_q;
  logic signed [SAMPLE_W-1:0] ltop_q, utop_q;
  logic [AW-1:0]              idx_q;
  logic [CW-1:0]              lcnt_q, ucnt_q;
  logic                       sel_q, has_r_q, dropped_q;
  logic                       out_valid_q;
  logic signed [MEDIAN_W-1:0] med_q;
  logic [COUNT_W-1:0]         cnt_out_q;
  logic                       dropped_out_q;

  logic                       sel_d, is_max;
  logic [CW-1:0]              cnt_sel, cnt_other, cnt_new;
  logic [IW-1:0]              idx_w, parent_w, l_w, r_w;
  logic [TW-1:0]              total_w;
  logic signed [SAMPLE_W-1:0] rdata, rdata_l, rdata_u, child, wdata;
  logic [AW-1:0]              raddr, waddr, cidx;
  logic                       we, pick_r;
  logic signed [MEDIAN_W-1:0] med_w;

  // Heap geometry around the hole.
  assign is_max   = (sel_q == HEAP_LOWER);
  assign cnt_sel  = (sel_q == HEAP_LOWER) ? lcnt_q : ucnt_q;
  assign cnt_other = (sel_q == HEAP_LOWER) ? ucnt_q : lcnt_q;
  assign idx_w    = IW'(idx_q);
  assign parent_w = (idx_w - IW'(1)) >> 1;
  assign l_w      = (idx_w << 1) + IW'(1);
  assign r_w      = l_w + IW'(1);
  assign total_w  = TW'(lcnt_q) + TW'(ucnt_q);
  assign rdata    = (sel_q == HEAP_LOWER) ? rdata_l : rdata_u;

  // Larger child for a max-heap, smaller for a min-heap.
  assign pick_r = has_r_q && ranks_above(rdata, left_q, is_max);
  assign child  = pick_r ? rdata : left_q;
  assign cidx   = pick_r ? AW'(r_w) : AW'(l_w);

  // Status toward the controller.
  always_comb begin
    status_o.full     = (total_w >= TW'(CAPACITY));
    status_o.idx_zero = (idx_q == '0);
    status_o.push_up  = ranks_above(val_q, rdata, is_max);
    status_o.rebal    = (IW'(lcnt_q) > IW'(ucnt_q) + IW'(1)) || (lcnt_q < ucnt_q);
    status_o.l_in     = (l_w < IW'(cnt_sel));
    status_o.pop_down = ranks_above(child, val_q, is_max);
    status_o.out_full = out_valid_q && !out_if.ready;
  end

  // Heap select for insertion and for the rebalancing pop.
  always_comb begin
    sel_d = sel_q;
    if (op_i == OP_INSERT) begin
      sel_d = (lcnt_q == '0 || ltop_q >= sample_q) ? HEAP_LOWER : HEAP_UPPER;
    end else if (op_i == OP_POP_START) begin
      sel_d = (lcnt_q > ucnt_q) ? HEAP_LOWER : HEAP_UPPER;
    end else if (op_i == OP_POP_WR) begin
      sel_d = ~sel_q;
    end
  end

  assign cnt_new = (sel_d == HEAP_LOWER) ? lcnt_q : ucnt_q;

  // RAM port steering.
  always_comb begin
    raddr = AW'(parent_w);
    waddr = idx_q;
    wdata = val_q;
    we    = 1'b0;
    case (op_i)
      OP_POP_START: raddr = AW'(cnt_new - CW'(1));
      OP_POP_RD:    raddr = AW'(l_w);
      OP_POP_RDL:   raddr = AW'(r_w);
      OP_PUSH_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_POP_MOVE: begin
        we    = 1'b1;
        wdata = child;
      end
      OP_PUSH_WR, OP_POP_WR: we = 1'b1;
      default: ;
    endcase
  end

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HeapDepth)) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (we && (sel_q == HEAP_LOWER)),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_l)
  );

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HeapDepth)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (we && (sel_q == HEAP_UPPER)),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_u)
  );

  // Sift registers: hole index, moving value, child data, popped top.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: sample_q <= sample_i;
      OP_INSERT: begin
        val_q <= sample_q;
        idx_q <= AW'(cnt_new);
      end
      OP_PUSH_MOVE: idx_q <= AW'(parent_w);
      OP_POP_START: top_q <= (sel_d == HEAP_LOWER) ? ltop_q : utop_q;
      OP_POP_LAST: begin
        val_q <= rdata;
        idx_q <= '0;
      end
      OP_POP_RDL: begin
        left_q  <= rdata;
        has_r_q <= (r_w < IW'(cnt_sel));
      end
      OP_POP_MOVE: idx_q <= cidx;
      OP_POP_WR: begin
        val_q <= top_q;
        idx_q <= AW'(cnt_other);
      end
      default: ;
    endcase
    // Keep a copy of each heap's root.
    if (we && waddr == '0) begin
      if (sel_q == HEAP_LOWER) ltop_q <= wdata;
      else utop_q <= wdata;
    end
  end

  // Heap counts and control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q    <= '0;
      ucnt_q    <= '0;
      sel_q     <= HEAP_LOWER;
      dropped_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      case (op_i)
        OP_DROP:   dropped_q <= 1'b1;
        OP_INSERT: dropped_q <= 1'b0;
        OP_PUSH_WR: begin
          if (sel_q == HEAP_LOWER) lcnt_q <= lcnt_q + CW'(1);
          else ucnt_q <= ucnt_q + CW'(1);
        end
        OP_POP_START: begin
          if (sel_d == HEAP_LOWER) lcnt_q <= lcnt_q - CW'(1);
          else ucnt_q <= ucnt_q - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Doubled median from the two roots.
  always_comb begin
    if (lcnt_q == '0) begin
      med_w = '0;
    end else if (lcnt_q == ucnt_q) begin
      med_w = MEDIAN_W'(ltop_q) + MEDIAN_W'(utop_q);
    end else begin
      med_w = MEDIAN_W'(ltop_q) <<< 1;
    end
  end

  // Output register decouples the receiver from the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The whole result is held here, so the next request may proceed meanwhile.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_OUT) begin
      med_q         <= med_w;
      cnt_out_q     <= COUNT_W'(total_w);
      dropped_out_q <= dropped_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.median_doubled = med_q;
  assign out_if.dropped        = dropped_out_q;
  assign out_if.stored_count   = cnt_out_q;

endmodule

// ===== sv/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps: streaming median over two heaps
// Top level joining the sequencer and the heap datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one signed 32-bit sample per request; out_if returns one
//   result per request: twice the median of all held samples, a drop flag,
//   and the number of held samples. When CAPACITY samples are held, a new
//   sample is dropped and the current median is returned with dropped set.
//   An item runs the sift-up of the new sample and, when the heaps are out
//   of balance, a pop of the larger heap's root with a sift-down and a
//   second sift-up into the other heap; each sift-down level steps through
//   S_POP_CHK, S_POP_RDL and S_POP_CMP, since the two children are read one
//   after the other through the single read port of the heap RAM. A dropped
//   sample skips the heaps.
//   in_if.ready is high only while the sequencer is idle. A finished result
//   waits in an output register, so the next sample is taken while the
//   receiver stalls; the sequencer waits only if a second result is ready
//   before the first is taken.
//   Reset clears the heap counts; the heap RAMs need no clearing, since an
//   entry's read data is never used before it is written.
// ----------------------------------------------------------------------------
module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmth_in_if.sink    in_if,
  rmth_out_if.source out_if
);

  dp_op_e     op;
  dp_status_t status;

  rmth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .op_o       (op)
  );

  rmth_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (in_if.sample),
    .op_i     (op),
    .status_o (status),
    .out_if   (out_if)
  );

endmodule

// ===== verif/running_median_two_heaps_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_tb: self-checking bench of the streaming median
// Feeds signed samples through the request channel, tracks the two heaps in
// its own model, and compares every result (doubled median, drop flag, held
// count) in order. It fills the store past capacity and uses random gaps,
// a long receiver stall and a drain pause on the sender side.
// ----------------------------------------------------------------------------
module running_median_two_heaps_tb;
  import rmth_pkg::*;

  localparam int unsigned HEAP_SLOTS = CAPACITY_DEF / 2 + 2;
  localparam int unsigned RAND_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT = 900000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SEL_LOWER = 0;
  localparam int unsigned SEL_UPPER = 1;

  typedef struct {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic                       dropped;
    logic [COUNT_W-1:0]         stored_count;
  } median_res_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    median_res_t                res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rmth_in_if  in_bus ();
  rmth_out_if out_bus ();

  running_median_two_heaps u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  // Model of the two heaps: index SEL_LOWER is the max-heap, SEL_UPPER the min-heap.
  logic signed [SAMPLE_W-1:0] heap_mem[2][HEAP_SLOTS];
  int unsigned                heap_cnt[2];

  median_res_t pending_medians[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned drops_seen;
  int unsigned items_sent;
  int unsigned cycles;
  bit          hold_req;
  bit          fast_mode;

  // Sample a belongs above sample b in the selected heap.
  function automatic bit outranks(logic signed [SAMPLE_W-1:0] a,
                                  logic signed [SAMPLE_W-1:0] b, int unsigned sel);
    return (sel == SEL_LOWER) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(int unsigned sel, logic signed [SAMPLE_W-1:0] v);
    int unsigned i;
    int unsigned p;
    logic signed [SAMPLE_W-1:0] t;
    i = heap_cnt[sel];
    if (i >= HEAP_SLOTS) return;
    heap_mem[sel][i] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(heap_mem[sel][i], heap_mem[sel][p], sel)) break;
      t = heap_mem[sel][i];
      heap_mem[sel][i] = heap_mem[sel][p];
      heap_mem[sel][p] = t;
      i = p;
    end
    heap_cnt[sel]++;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] heap_extract(int unsigned sel);
    logic signed [SAMPLE_W-1:0] top;
    logic signed [SAMPLE_W-1:0] t;
    int unsigned n;
    int unsigned i;
    int unsigned l;
    int unsigned c;
    top = heap_mem[sel][0];
    n = heap_cnt[sel] - 1;
    heap_cnt[sel] = n;
    heap_mem[sel][0] = heap_mem[sel][n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      c = l;
      if (l >= n) break;
      if (l + 1 < n && outranks(heap_mem[sel][l+1], heap_mem[sel][l], sel)) c = l + 1;
      if (!outranks(heap_mem[sel][c], heap_mem[sel][i], sel)) break;
      t = heap_mem[sel][i];
      heap_mem[sel][i] = heap_mem[sel][c];
      heap_mem[sel][c] = t;
      i = c;
    end
    return top;
  endfunction

  // Adds one sample to the model and returns the result the block should give.
  function automatic median_res_t median_after(logic signed [SAMPLE_W-1:0] s);
    median_res_t r;
    r.dropped = 1'b0;
    if (heap_cnt[SEL_LOWER] + heap_cnt[SEL_UPPER] >= CAPACITY_DEF) begin
      r.dropped = 1'b1;
    end else begin
      if (heap_cnt[SEL_LOWER] == 0 || heap_mem[SEL_LOWER][0] >= s) begin
        heap_insert(SEL_LOWER, s);
      end else begin
        heap_insert(SEL_UPPER, s);
      end
      if (heap_cnt[SEL_LOWER] > heap_cnt[SEL_UPPER] + 1) begin
        heap_insert(SEL_UPPER, heap_extract(SEL_LOWER));
      end else if (heap_cnt[SEL_LOWER] < heap_cnt[SEL_UPPER]) begin
        heap_insert(SEL_LOWER, heap_extract(SEL_UPPER));
      end
    end
    if (heap_cnt[SEL_LOWER] == heap_cnt[SEL_UPPER]) begin
      r.median_doubled = MEDIAN_W'(heap_mem[SEL_LOWER][0]) + MEDIAN_W'(heap_mem[SEL_UPPER][0]);
    end else begin
      r.median_doubled = MEDIAN_W'(heap_mem[SEL_LOWER][0]) <<< 1;
    end
    r.stored_count = COUNT_W'(heap_cnt[SEL_LOWER] + heap_cnt[SEL_UPPER]);
    return r;
  endfunction

  // Clock and a single reset at the start.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Offers one sample, after a random gap unless in fast mode, and records the expected result.
  task automatic offer_sample(logic signed [SAMPLE_W-1:0] s, bit typed, median_res_t given);
    int unsigned gap;
    median_res_t r;
    gap = fast_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.sample = s;
    do @(posedge clk); while (!in_bus.ready);
    r = median_after(s);
    pending_medians.push_back(typed ? given : r);
    items_sent++;
    @(negedge clk);
  endtask

  // Random sample: full range, a crowded small range, or near the extremes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0, 1: return $urandom;
      2: return $signed(SAMPLE_W'($urandom_range(0, 16))) - 8;
      default: begin
        if ($urandom_range(0, 1)) return 32'sh7fffffff - $urandom_range(0, 3);
        return 32'sh80000000 + $urandom_range(0, 3);
      end
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned wait_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      wait_n = fast_mode ? 0 : $urandom_range(0, 4);
      if (wait_n > 0) begin
        out_bus.ready = 1'b0;
        repeat (wait_n - 1) @(negedge clk);
        @(negedge clk);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    median_res_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (out_bus.dropped) drops_seen++;
      if (pending_medians.size() == 0) begin
        $display("%0t: result with nothing expected: median %0d", $time,
                 out_bus.median_doubled);
        errors++;
      end else begin
        e = pending_medians.pop_front();
        if (out_bus.median_doubled !== e.median_doubled) begin
          $display("%0t: median_doubled expected %0d actual %0d", $time,
                   e.median_doubled, out_bus.median_doubled);
          errors++;
        end
        if (out_bus.dropped !== e.dropped) begin
          $display("%0t: dropped expected %0b actual %0b", $time, e.dropped,
                   out_bus.dropped);
          errors++;
        end
        if (out_bus.stored_count !== e.stored_count) begin
          $display("%0t: stored_count expected %0d actual %0d", $time,
                   e.stored_count, out_bus.stored_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_medians.size());
      $display("running_median_two_heaps: mismatch");
      $finish;
    end
  end

  // Stimulus: directed rows first, then random samples past capacity.
  initial begin
    stim_row_t rows[14];
    median_res_t none;
    int unsigned k;
    errors = 0;
    results_seen = 0;
    drops_seen = 0;
    items_sent = 0;
    cycles = 0;
    hold_req = 1'b0;
    fast_mode = 1'b0;
    heap_cnt[SEL_LOWER] = 0;
    heap_cnt[SEL_UPPER] = 0;
    none = '{default: '0};
    // First sample alone: twice itself. Second: the sum of the two extremes.
    rows[0] = '{32'sh7fffffff, 1'b1, '{33'sh0fffffffe, 1'b0, 11'd1}};
    rows[1] = '{32'sh80000000, 1'b1, '{-33'sd1, 1'b0, 11'd2}};
    rows[2] = '{32'sh80000000, 1'b1, '{-33'sh100000000, 1'b0, 11'd3}};
    rows[3] = '{32'sh7fffffff, 1'b0, none};
    rows[4] = '{32'sh7fffffff, 1'b0, none};
    rows[5] = '{32'sd0, 1'b0, none};
    rows[6] = '{-32'sd1, 1'b0, none};
    rows[7] = '{32'sd1, 1'b0, none};
    rows[8] = '{32'sd0, 1'b0, none};
    rows[9] = '{32'sh55555555, 1'b0, none};
    rows[10] = '{32'shaaaaaaaa, 1'b0, none};
    rows[11] = '{32'sh80000000, 1'b0, none};
    rows[12] = '{-32'sd2, 1'b0, none};
    rows[13] = '{32'sd2, 1'b0, none};
    @(posedge rst_n);
    @(negedge clk);
    foreach (rows[i]) offer_sample(rows[i].sample, rows[i].typed, rows[i].res);

    for (k = 0; k < RAND_ITEMS; k++) begin
      // Long receiver hold-off while samples keep coming.
      if (k == 300) hold_req = 1'b1;
      // Sender drains completely once.
      if (k == 600) begin
        in_bus.valid = 1'b0;
        while (pending_medians.size() != 0) @(negedge clk);
      end
      fast_mode = (k >= 800 && k < 900) || (k >= 1200 && k < 1260);
      offer_sample(pick_sample(), 1'b0, none);
    end
    in_bus.valid = 1'b0;
    fast_mode = 1'b0;

    while (pending_medians.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Sent %0d samples, checked %0d results, %0d of them dropped at capacity.",
             items_sent, results_seen, drops_seen);
    $display("Covered extremes, duplicates, a long output stall and a full drain.");
    if (errors == 0) begin
      $display("running_median_two_heaps: match");
    end else begin
      $display("running_median_two_heaps: mismatch");
    end
    $finish;
  end

endmodule

// ===== running_median_two_heaps.f =====
sv/rmth_pkg.sv
sv/rmth_in_if.sv
sv/rmth_out_if.sv
sv/rmth_ram.sv
sv/rmth_ctrl.sv
sv/rmth_dp.sv
sv/running_median_two_heaps.sv
verif/running_median_two_heaps_tb.sv
